[rtl/btk_pkg.sv]
// Shared types, constants and codes of the bounded top-k tracker.
package btk_pkg;

    localparam int DEPTH   = 64;
    localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ID_W    = 20;
    localparam int SCORE_W = 16;
    localparam int CAP_W   = 7;
    localparam int STAT_W  = 3;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    // Minimum search: first pass reduces groups, second pass reduces group winners.
    localparam int NGRP   = 8;
    localparam int GRP_SZ = (DEPTH + NGRP - 1) / NGRP;

    localparam logic CAPACITY_REG = 1'b0;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(64);

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERT = 3'd0,
        ST_EVICT  = 3'd1,
        ST_DUP    = 3'd2,
        ST_REJECT = 3'd3,
        ST_DRAIN  = 3'd4,
        ST_EMPTY  = 3'd5
    } t_status;

    typedef struct packed {
        logic valid;
        logic [SCORE_W-1:0] score;
        logic [ID_W-1:0] id;
        logic [SLOT_W-1:0] slot;
    } t_cand;

    typedef struct packed {
        logic capture;
        logic eval;
        logic commit;
        logic drain_step;
        logic drain_empty;
    } t_cmd;

    typedef struct packed {
        logic in_drain;
        logic out_free;
        logic any_valid;
        logic drain_last;
    } t_stat;

endpackage

[rtl/bounded_topk_tracker_core.sv]
// Top level of the bounded top-k tracker: register port, sequencer and datapath.
//
//  channel   direction  handshake             payload
//  input     in         i_valid / o_stall     i_opcode, i_entry_id, i_score
//  result    out        o_valid / i_stall     o_status, o_out_id, o_out_score, o_last
//  config    in         psel/penable/pwrite   paddr, pwdata -> prdata, pready
//
// Offer: the word is captured, then the parallel id match and the first minimum pass are
// registered, then the store is updated and the result word loaded; the input stays blocked
// until then, so a new offer is taken only once the last one has loaded its result word.
// Drain: a start state, then one word per held entry, one per cycle while the result side is not stalled.
// Reset is synchronous, active low; it empties the store and sets capacity to 64.
// A step that loads a result word waits while the word in place is stalled.
module bounded_topk_tracker_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input words
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic [btk_pkg::ID_W-1:0]      i_entry_id,
    input  logic [btk_pkg::SCORE_W-1:0]   i_score,
    // result words
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [btk_pkg::STAT_W-1:0]    o_status,
    output logic [btk_pkg::ID_W-1:0]      o_out_id,
    output logic [btk_pkg::SCORE_W-1:0]   o_out_score,
    output logic                          o_last,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [btk_pkg::PADDR_W-1:0]   paddr,
    input  logic [btk_pkg::PDATA_W-1:0]   pwdata,
    output logic [btk_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [btk_pkg::CAP_W-1:0] r_capacity;
    btk_pkg::t_cmd             cmd;
    btk_pkg::t_stat            stat;
    logic                      cap_sel;

    // Word address bit picks the register; byte offset bits are ignored.
    assign cap_sel = (paddr[btk_pkg::PADDR_W-1] == btk_pkg::CAPACITY_REG);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= btk_pkg::CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready && cap_sel) begin
            r_capacity <= pwdata[btk_pkg::CAP_W-1:0];
        end
    end

    assign prdata = cap_sel ? btk_pkg::PDATA_W'(r_capacity) : '0;

    btk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    btk_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_capacity  (r_capacity),
        .i_opcode    (i_opcode),
        .i_entry_id  (i_entry_id),
        .i_score     (i_score),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_out_id    (o_out_id),
        .o_out_score (o_out_score),
        .o_last      (o_last)
    );

`ifndef SYNTHESIS
    // An offer taken with the result side empty has its word valid after the match and decide states, with no wait.
    a_offer_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_opcode == btk_pkg::OP_OFFER) && !o_valid)
            |=> ##2 o_valid)
        else $error("offer result late");

    // A word that is not the last of its drain comes while input stays blocked.
    a_drain_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_stall)
        else $error("input open during drain");

    // Only drained entries can be non-final words.
    a_nonlast_is_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_status == btk_pkg::ST_DRAIN))
        else $error("non-final word is not a drained entry");
`endif

endmodule

[rtl/btk_ctrl.sv]
// Sequencer of the bounded top-k tracker: offer and drain control.
module btk_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  btk_pkg::t_stat i_stat,
    output btk_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_DECIDE,
        S_DRAIN0,
        S_DRAIN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   accept;

    assign accept  = i_valid && !r_busy;
    assign o_stall = r_busy;

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_busy        = 1'b1;
                    n_state       = i_stat.in_drain ? S_DRAIN0 : S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.eval = 1'b1;
                n_state    = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_busy       = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            S_DRAIN0: begin
                if (i_stat.out_free) begin
                    if (!i_stat.any_valid) begin
                        o_cmd.drain_empty = 1'b1;
                        n_busy            = 1'b0;
                        n_state           = S_IDLE;
                    end else begin
                        o_cmd.drain_step = 1'b1;
                        if (i_stat.drain_last) begin
                            n_busy  = 1'b0;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_DRAIN;
                        end
                    end
                end
            end
            S_DRAIN: begin
                if (i_stat.out_free) begin
                    o_cmd.drain_step = 1'b1;
                    if (i_stat.drain_last) begin
                        n_busy  = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

endmodule

[rtl/btk_dpath.sv]
// Datapath of the bounded top-k tracker: entry store, id match, minimum search, result word.
module btk_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  btk_pkg::t_cmd                 i_cmd,
    output btk_pkg::t_stat                o_stat,
    input  logic [btk_pkg::CAP_W-1:0]     i_capacity,
    input  logic                          i_opcode,
    input  logic [btk_pkg::ID_W-1:0]      i_entry_id,
    input  logic [btk_pkg::SCORE_W-1:0]   i_score,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [btk_pkg::STAT_W-1:0]    o_status,
    output logic [btk_pkg::ID_W-1:0]      o_out_id,
    output logic [btk_pkg::SCORE_W-1:0]   o_out_score,
    output logic                          o_last
);

    // Entry store
    logic [btk_pkg::ID_W-1:0]    r_ids    [btk_pkg::DEPTH];
    logic [btk_pkg::SCORE_W-1:0] r_scores [btk_pkg::DEPTH];
    logic [btk_pkg::DEPTH-1:0]   r_valid;
    logic [btk_pkg::CNT_W-1:0]   r_count;

    // Captured offer and first-pass results
    logic [btk_pkg::ID_W-1:0]    r_id;
    logic [btk_pkg::SCORE_W-1:0] r_sc;
    logic                        r_match;
    logic [btk_pkg::SLOT_W-1:0]  r_free_slot;
    btk_pkg::t_cand              r_cand [btk_pkg::NGRP];

    // Result word
    logic                          r_out_valid;
    btk_pkg::t_status              r_status;
    logic [btk_pkg::ID_W-1:0]      r_out_id;
    logic [btk_pkg::SCORE_W-1:0]   r_out_score;
    logic                          r_last;

    logic                        match;
    logic [btk_pkg::SLOT_W-1:0]  free_slot;
    btk_pkg::t_cand              grp_best [btk_pkg::NGRP];
    btk_pkg::t_cand              min_best;
    logic [btk_pkg::CMP_W-1:0]   cap_eff;
    logic                        full;
    logic [btk_pkg::SLOT_W-1:0]  dr_slot;
    logic [btk_pkg::DEPTH-1:0]   dr_onehot;
    logic                        out_free;

    // Id match and lowest free slot over the whole store
    always_comb begin
        match     = 1'b0;
        free_slot = '0;
        for (int i = 0; i < btk_pkg::DEPTH; i++) begin
            if (r_valid[i] && (r_ids[i] == r_id)) match = 1'b1;
        end
        for (int i = btk_pkg::DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) free_slot = btk_pkg::SLOT_W'(i);
        end
    end

    // First pass of the minimum search: one winner per group, lowest slot wins ties
    always_comb begin
        btk_pkg::t_cand c;
        for (int g = 0; g < btk_pkg::NGRP; g++) begin
            grp_best[g] = '0;
            for (int k = 0; k < btk_pkg::GRP_SZ; k++) begin
                if (g * btk_pkg::GRP_SZ + k < btk_pkg::DEPTH) begin
                    c.valid = r_valid[g * btk_pkg::GRP_SZ + k];
                    c.score = r_scores[g * btk_pkg::GRP_SZ + k];
                    c.id    = r_ids[g * btk_pkg::GRP_SZ + k];
                    c.slot  = btk_pkg::SLOT_W'(g * btk_pkg::GRP_SZ + k);
                    if (c.valid && (!grp_best[g].valid || c.score < grp_best[g].score))
                        grp_best[g] = c;
                end
            end
        end
    end

    // Second pass over the registered group winners
    always_comb begin
        min_best = '0;
        for (int g = 0; g < btk_pkg::NGRP; g++) begin
            if (r_cand[g].valid && (!min_best.valid || r_cand[g].score < min_best.score))
                min_best = r_cand[g];
        end
    end

    // Clamp capacity into 1..DEPTH
    always_comb begin
        cap_eff = btk_pkg::CMP_W'(i_capacity);
        if (cap_eff == '0) cap_eff = btk_pkg::CMP_W'(1);
        if (cap_eff > btk_pkg::CMP_W'(btk_pkg::DEPTH)) cap_eff = btk_pkg::CMP_W'(btk_pkg::DEPTH);
        full = btk_pkg::CMP_W'(r_count) >= cap_eff;
    end

    // Drain pick: lowest valid slot
    always_comb begin
        dr_slot = '0;
        for (int i = btk_pkg::DEPTH - 1; i >= 0; i--) begin
            if (r_valid[i]) dr_slot = btk_pkg::SLOT_W'(i);
        end
        dr_onehot = btk_pkg::DEPTH'(1) << dr_slot;
    end

    assign out_free = !r_out_valid || !i_stall;

    assign o_stat.in_drain   = (i_opcode == btk_pkg::OP_DRAIN);
    assign o_stat.out_free   = out_free;
    assign o_stat.any_valid  = |r_valid;
    assign o_stat.drain_last = ((r_valid & ~dr_onehot) == '0);

    // Capture and first pass registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_id <= i_entry_id;
            r_sc <= i_score;
        end
        if (i_cmd.eval) begin
            r_match     <= match;
            r_free_slot <= free_slot;
            for (int g = 0; g < btk_pkg::NGRP; g++) r_cand[g] <= grp_best[g];
        end
    end

    // Store payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !r_match) begin
            if (full) begin
                if (min_best.valid && (r_sc > min_best.score)) begin
                    r_ids[min_best.slot]    <= r_id;
                    r_scores[min_best.slot] <= r_sc;
                end
            end else begin
                r_ids[r_free_slot]    <= r_id;
                r_scores[r_free_slot] <= r_sc;
            end
        end
    end

    // Store occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_cmd.commit && !r_match && !full) begin
            r_valid[r_free_slot] <= 1'b1;
            r_count              <= r_count + btk_pkg::CNT_W'(1);
        end else if (i_cmd.drain_step) begin
            r_valid[dr_slot] <= 1'b0;
            r_count          <= r_count - btk_pkg::CNT_W'(1);
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit || i_cmd.drain_step || i_cmd.drain_empty) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_last      <= 1'b1;
            r_out_id    <= r_id;
            r_out_score <= r_sc;
            if (r_match) begin
                r_status <= btk_pkg::ST_DUP;
            end else if (!full) begin
                r_status <= btk_pkg::ST_INSERT;
            end else if (min_best.valid && (r_sc > min_best.score)) begin
                r_status    <= btk_pkg::ST_EVICT;
                r_out_id    <= min_best.id;
                r_out_score <= min_best.score;
            end else begin
                r_status <= btk_pkg::ST_REJECT;
            end
        end else if (i_cmd.drain_step) begin
            r_status    <= btk_pkg::ST_DRAIN;
            r_out_id    <= r_ids[dr_slot];
            r_out_score <= r_scores[dr_slot];
            r_last      <= ((r_valid & ~dr_onehot) == '0);
        end else if (i_cmd.drain_empty) begin
            r_status    <= btk_pkg::ST_EMPTY;
            r_out_id    <= '0;
            r_out_score <= '0;
            r_last      <= 1'b1;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_out_id    = r_out_id;
    assign o_out_score = r_out_score;
    assign o_last      = r_last;

endmodule
